@@ rtl/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and sizing constants for the stable rank sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int CMP_W       = NUM_GROUPS * GROUP_SIZE;
   localparam int GCNT_W      = $clog2(GROUP_SIZE + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] value;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] sorted_value;
      logic       last_out;
      logic       overflow;
   } rsp_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic [7:0]       value;
      logic             last;
      logic             drop;
      logic [IDX_W-1:0] idx;
   } qentry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

`default_nettype wire

@@ rtl/srs_front.sv @@
// ----------------------------------------------------------------------------
// srs_front
// Accepts input beats, assigns each a store slot or marks it dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire srs_pkg::req_type   req_data,
   input  wire srs_pkg::qstat_type q_stat,
   output logic                    push,
   output srs_pkg::qentry_type     push_data
);
   import srs_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             drop;

   always_comb begin
      busy   = q_stat.full || reset;
      push   = start && !busy;
      drop   = (cnt_ff == CNT_W'(MAX_ITEMS));
      cnt_in = cnt_ff;
      push_data.value = req_data.value;
      push_data.last  = req_data.last_in;
      push_data.drop  = drop;
      push_data.idx   = cnt_ff[IDX_W-1:0];
      if (push) begin
         if (req_data.last_in) begin
            cnt_in = '0;
         end else if (!drop) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/srs_queue.sv @@
// ----------------------------------------------------------------------------
// srs_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire srs_pkg::qentry_type  push_data,
   input  wire logic                 pop,
   output srs_pkg::qentry_type       pop_data,
   output srs_pkg::qstat_type        q_stat
);
   import srs_pkg::*;

   qentry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      q_stat.empty = (count_ff == '0);
      q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      pop_data     = entry_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/srs_back.sv @@
// ----------------------------------------------------------------------------
// srs_back
// Stores a run, ranks every entry against a row of compare cells, places
// each value at its rank and streams the placed values out.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire srs_pkg::qentry_type pop_data,
   input  wire srs_pkg::qstat_type  q_stat,
   output logic                     pop,
   output logic                     rsp_strobe,
   output srs_pkg::rsp_type         rsp_data
);
   import srs_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_RANK = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             run_ovf_ff, run_ovf_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_done_ff, issue_done_in;

   logic [7:0]       item_mem_ff   [MAX_ITEMS];
   logic [7:0]       placed_mem_ff [MAX_ITEMS];
   logic [7:0]       cell_ff       [MAX_ITEMS];

   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [7:0]       s1_val_ff, s2_val_ff, s3_val_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [GCNT_W-1:0] grp_ff [NUM_GROUPS];
   logic [GCNT_W-1:0] grp_in [NUM_GROUPS];
   logic [CNT_W-1:0] rank_ff, rank_in;

   logic             em_vld_ff, em_vld_in;
   logic             em_last_ff, em_last_in;
   logic [7:0]       em_val_ff;

   logic             issue;
   logic             emit;
   logic             at_end;
   logic [CMP_W-1:0] cmp;

   assign at_end = (CNT_W'(addr_ff) == cnt_ff - 1'b1);
   assign issue  = (state_ff == ST_RANK) && !issue_done_ff;
   assign emit   = (state_ff == ST_EMIT);
   assign pop    = (state_ff == ST_LOAD) && !q_stat.empty;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      run_ovf_in    = run_ovf_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (pop_data.drop) begin
                  ovf_in = 1'b1;
               end
               if (pop_data.last) begin
                  cnt_in        = pop_data.drop ? CNT_W'(MAX_ITEMS)
                                                : CNT_W'(pop_data.idx) + 1'b1;
                  run_ovf_in    = ovf_ff || pop_data.drop;
                  ovf_in        = 1'b0;
                  addr_in       = '0;
                  issue_done_in = 1'b0;
                  state_in      = ST_RANK;
               end
            end
         end
         ST_RANK: begin
            if (!issue_done_ff) begin
               if (at_end) begin
                  addr_in       = '0;
                  issue_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end else if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               addr_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (at_end) begin
               addr_in  = '0;
               state_in = ST_LOAD;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // one compare cell per stored entry: counts entries that sort ahead
   for (genvar k = 0; k < CMP_W; k++) begin : g_cell
      if (k < MAX_ITEMS) begin : g_live
         assign cmp[k] = (CNT_W'(k) < cnt_ff) &&
                         ((cell_ff[k] < s1_val_ff) ||
                          ((cell_ff[k] == s1_val_ff) && (IDX_W'(k) < s1_idx_ff)));
      end else begin : g_pad
         assign cmp[k] = 1'b0;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = GCNT_W'($countones(cmp[g*GROUP_SIZE +: GROUP_SIZE]));
      end
   end

   always_comb begin
      rank_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rank_in = rank_in + CNT_W'(grp_ff[g]);
      end
   end

   assign em_vld_in  = emit;
   assign em_last_in = emit && at_end;

   always_ff @(posedge clock) begin
      if (pop && !pop_data.drop) begin
         item_mem_ff[pop_data.idx] <= pop_data.value;
         cell_ff[pop_data.idx]     <= pop_data.value;
      end
      if (issue) begin
         s1_val_ff <= item_mem_ff[addr_ff];
         s1_idx_ff <= addr_ff;
      end
      s2_val_ff <= s1_val_ff;
      grp_ff    <= grp_in;
      s3_val_ff <= s2_val_ff;
      rank_ff   <= rank_in;
      if (s3_vld_ff) begin
         placed_mem_ff[rank_ff[IDX_W-1:0]] <= s3_val_ff;
      end
      if (emit) begin
         em_val_ff <= placed_mem_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         run_ovf_ff    <= 1'b0;
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         em_vld_ff     <= 1'b0;
         em_last_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ovf_ff        <= ovf_in;
         run_ovf_ff    <= run_ovf_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         s1_vld_ff     <= issue;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         em_vld_ff     <= em_vld_in;
         em_last_ff    <= em_last_in;
      end
   end

   always_comb begin
      rsp_strobe             = em_vld_ff;
      rsp_data.sorted_value  = em_val_ff;
      rsp_data.last_out      = em_last_ff;
      rsp_data.overflow      = run_ovf_ff;
   end

endmodule

`default_nettype wire

@@ rtl/stable_rank_sort.sv @@
// ----------------------------------------------------------------------------
// stable_rank_sort
// Stable rank sort of a run of bytes: store, rank, emit in ascending order.
//
//   channel   ports                      handshake
//   input     start, busy, req_data      taken when start && !busy
//   result    rsp_strobe, rsp_data       one result per cycle, no stall
//
// Loading takes one beat per cycle through a two-entry queue while busy is low.
// With the back idle, the last beat of a run is popped in the cycle after it
// is taken; the stored values are then ranked, the compare and count pipeline
// drains, and the values are emitted through one output register.
// busy is high in reset and once the queue holds two beats, which happens
// only while the back ranks or emits.
// Reset clears all control state; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_rank_sort (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire srs_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output srs_pkg::rsp_type      rsp_data
);
   import srs_pkg::*;

   logic       push;
   logic       pop;
   qentry_type push_data;
   qentry_type pop_data;
   qstat_type  q_stat;

   srs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   srs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   srs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data   (pop_data),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/srs_checker.sv @@
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks on the sorter's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire srs_pkg::rsp_type rsp_data
);
   import srs_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && (!busy || reset))
      else $error("output or busy active right after reset");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=> rsp_strobe)
      else $error("gap inside a run's results");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=>
         rsp_data.sorted_value >= $past(rsp_data.sorted_value))
      else $error("results not ascending");

   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=>
         rsp_data.overflow == $past(rsp_data.overflow))
      else $error("overflow flag changed within a run");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted beat");

endmodule

bind stable_rank_sort srs_checker u_srs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_rank_sort. A queued driver feeds runs of
// bytes over the start/busy port and idles at random. A monitor checks each
// strobed result against a software ranker that tracks the sorter's fill
// count and overflow flag. Runs cover one entry, duplicate values, a full
// store, a dropped last beat and long overflowing runs.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srs_pkg::*;

   localparam int IDLE_PCT     = 19;
   localparam int QUIET_FIRST  = 160;
   localparam int QUIET_LAST   = 260;
   localparam int BEAT_TARGET  = 420;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type          beat_q[$];
   rsp_type          sorted_due[$];
   logic [7:0]       run_store[MAX_ITEMS];
   logic [CNT_W-1:0] run_fill = '0;
   logic             run_dropped = 1'b0;
   int               beats_taken = 0;
   int               cycle_count = 0;
   int               fault_count = 0;

   stable_rank_sort uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // store a beat; on the last one rank the run and queue the sorted results
   task automatic absorb_beat(input req_type beat);
      logic [7:0] placed[MAX_ITEMS];
      rsp_type    res;
      int         i;
      int         k;
      int         rank;
      if (run_fill < MAX_ITEMS) begin
         run_store[run_fill] = beat.value;
         run_fill = run_fill + 1'b1;
      end else begin
         run_dropped = 1'b1;
      end
      if (beat.last_in) begin
         for (i = 0; i < run_fill; i++) begin
            rank = 0;
            for (k = 0; k < run_fill; k++) begin
               if (run_store[k] < run_store[i] || (run_store[k] == run_store[i] && k < i))
                  rank++;
            end
            placed[rank] = run_store[i];
         end
         for (i = 0; i < run_fill; i++) begin
            res.sorted_value = placed[i];
            res.last_out     = (i == run_fill - 1);
            res.overflow     = run_dropped;
            sorted_due.push_back(res);
         end
         run_fill    = '0;
         run_dropped = 1'b0;
      end
   endtask

   task automatic push_beat(input logic [7:0] v, input logic l);
      req_type beat;
      beat.value   = v;
      beat.last_in = l;
      beat_q.push_back(beat);
   endtask

   // narrow runs draw from four values so duplicates are common
   task automatic push_run(input int len, input bit narrow);
      logic [7:0] pal[4];
      logic [7:0] v;
      int         n;
      foreach (pal[j]) pal[j] = 8'($urandom_range(255));
      for (n = 0; n < len; n++) begin
         v = narrow ? pal[$urandom_range(3)] : 8'($urandom_range(255));
         push_beat(v, n == len - 1);
      end
   endtask

   // driver: the head of beat_q is on req_data whenever start is high
   always @(posedge clock) begin
      logic taken;
      logic quiet;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            absorb_beat(req_data);
            void'(beat_q.pop_front());
            beats_taken++;
         end
         if (!start || taken) begin
            quiet = beats_taken >= QUIET_FIRST && beats_taken < QUIET_LAST;
            if (beat_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               start    <= 1'b1;
               req_data <= beat_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results cannot be stalled, so every strobe is checked
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            fault_count++;
         end else begin
            due = sorted_due.pop_front();
            if (rsp_data.sorted_value !== due.sorted_value) begin
               $display("%0t: sorted_value expected %h actual %h",
                        $time, due.sorted_value, rsp_data.sorted_value);
               fault_count++;
            end
            if (rsp_data.last_out !== due.last_out) begin
               $display("%0t: last_out expected %b actual %b",
                        $time, due.last_out, rsp_data.last_out);
               fault_count++;
            end
            if (rsp_data.overflow !== due.overflow) begin
               $display("%0t: overflow expected %b actual %b",
                        $time, due.overflow, rsp_data.overflow);
               fault_count++;
            end
         end
      end
   end

   initial begin
      int len;
      // single-entry runs at both extremes
      push_beat(8'h00, 1'b1);
      push_beat(8'hFF, 1'b1);
      // mixed extremes and bit patterns
      push_beat(8'hFF, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h80, 1'b0);
      push_beat(8'h7F, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'hFE, 1'b0);
      push_beat(8'h55, 1'b0);
      push_beat(8'hAA, 1'b1);
      // duplicates
      push_beat(8'h03, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'h03, 1'b0);
      push_beat(8'h03, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'h02, 1'b1);
      // descending
      push_beat(8'hFF, 1'b0);
      push_beat(8'hC0, 1'b0);
      push_beat(8'h80, 1'b0);
      push_beat(8'h40, 1'b0);
      push_beat(8'h00, 1'b1);
      // already sorted with repeats
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b1);
      // store exactly full, last beat dropped, long overflow
      push_run(MAX_ITEMS, 1'b0);
      push_run(MAX_ITEMS + 1, 1'b1);
      push_run(MAX_ITEMS + 6, 1'b0);
      while (beat_q.size() < BEAT_TARGET) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
                                        : $urandom_range(1, 12);
         push_run(len, $urandom_range(2) == 0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while ((beat_q.size() != 0 || start || sorted_due.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d beats and %0d results outstanding",
                  $time, beat_q.size(), sorted_due.size());
         fault_count++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
